/* rtl/core/bcd_dmc_pkg.sv */
// Shared types, constants and helper functions for the BCD display mode controller.
package bcd_dmc_pkg;

    localparam int unsigned STATION_W  = 6;
    localparam int unsigned ADDR_W     = 8;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned SHOWN_W    = 16;
    localparam int unsigned CODE_W     = 4;
    localparam int unsigned ENABLE_W   = 3;
    localparam int unsigned M1000_W    = 10;
    localparam int unsigned IN_DATA_W  = 80;
    localparam int unsigned OUT_DATA_W = 8;
    localparam int unsigned TEST_BIT   = 5;

    localparam logic [CODE_W-1:0]  CODE_BLANK = 4'd10;
    localparam logic [CODE_W-1:0]  DIGIT_MAX  = 4'd9;
    localparam logic [WORD_W-1:0]  TEST_WRAP  = 32'd900;
    localparam logic [WORD_W-1:0]  TEST_STEP1 = 32'd300;
    localparam logic [WORD_W-1:0]  TEST_STEP2 = 32'd600;
    localparam logic [WORD_W-1:0]  BLINK_WRAP = 32'd1000;
    localparam logic [M1000_W-1:0] M1000_LAST = 10'd999;
    localparam logic [M1000_W-1:0] BLINK_HALF = 10'd500;
    localparam logic [WORD_W-1:0]  TRIPLE_ONE = 32'd111;

    typedef enum logic [1:0] {
        SEL_UNITS,
        SEL_TENS,
        SEL_HUNDREDS
    } t_digit_sel;

    // Scan digit from the low counter byte: the byte modulo 3.
    function automatic t_digit_sel f_scan_sel(input logic [7:0] v);
        logic [3:0] s;
        t_digit_sel r;
        s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
        case (s)
            4'd0, 4'd3, 4'd6, 4'd9, 4'd12: r = SEL_UNITS;
            4'd1, 4'd4, 4'd7, 4'd10:        r = SEL_TENS;
            4'd2, 4'd5, 4'd8, 4'd11:        r = SEL_HUNDREDS;
            default:                        r = SEL_UNITS;
        endcase
        return r;
    endfunction

    // Units digit of a 32-bit word, built from its residues modulo 5 and modulo 2.
    function automatic logic [3:0] f_mod10_32(input logic [31:0] v);
        logic [6:0]  s;
        logic [14:0] p;
        logic [4:0]  q;
        logic [6:0]  rem;
        s = '0;
        for (int i = 0; i < 8; i++) begin
            s = s + 7'(v[4*i +: 4]);
        end
        p   = 15'(s) * 15'd205;
        q   = p[14:10];
        rem = s - 7'(q) * 7'd5;
        return (rem[0] == v[0]) ? 4'(rem) : 4'(rem) + 4'd5;
    endfunction

endpackage

/* rtl/core/bcd_dmc_digit.sv */
// Decimal digit extraction of the shown value for the selected scan position.
module bcd_dmc_digit (
    input  logic [bcd_dmc_pkg::SHOWN_W-1:0] i_value,
    input  bcd_dmc_pkg::t_digit_sel         i_sel,
    output logic [bcd_dmc_pkg::CODE_W-1:0]  o_digit
);
    import bcd_dmc_pkg::*;

    logic [31:0] p10;
    logic [28:0] p100;
    logic [26:0] p1000;
    logic [12:0] q10;
    logic [9:0]  q100;
    logic [6:0]  q1000;
    logic [15:0] d0_full;
    logic [12:0] d1_full;
    logic [9:0]  d2_full;

    assign p10   = 32'(i_value) * 32'd52429;
    assign p100  = 29'(i_value[15:2]) * 29'd20972;
    assign p1000 = 27'(i_value[15:3]) * 27'd8389;

    assign q10   = p10[31:19];
    assign q100  = p100[28:19];
    assign q1000 = p1000[26:20];

    assign d0_full = i_value - ({q10, 3'b000} + {2'b00, q10, 1'b0});
    assign d1_full = q10 - ({q100, 3'b000} + {2'b00, q100, 1'b0});
    assign d2_full = q100 - ({q1000, 3'b000} + {2'b00, q1000, 1'b0});

    always_comb begin
        case (i_sel)
            SEL_UNITS:    o_digit = d0_full[CODE_W-1:0];
            SEL_TENS:     o_digit = d1_full[CODE_W-1:0];
            SEL_HUNDREDS: o_digit = d2_full[CODE_W-1:0];
            default:      o_digit = d2_full[CODE_W-1:0];
        endcase
    end

endmodule

/* rtl/core/bcd_display_mode_controller.sv */
// Top level of the three-digit multiplexed BCD display mode controller.
//
// The slave stream carries one transaction per event: tuser low is a refresh
// tick, tuser high is a command frame. A frame whose address matches the
// station id, while the station id does not select test mode, loads the
// value, the mode flags and either hold mode or a duration in ticks. Frames
// produce no output. Every tick produces one master transaction with the
// digit enables, the BCD code and the decimal point level.
// The user must write the station id through the configuration port only
// while idle; the block does not enforce it. Each accepted transaction is
// registered, then processed into the display and output registers. One
// transaction is accepted per cycle while no tick waits on a stalled master;
// the limit is the single state update per cycle of the tick counter and
// display lines. Reset is synchronous and active low; it clears both stream
// registers and the display state, leaving the code at blank. A stalled
// master holds its result, and the slave side stays ready while the
// processing register can drain, so frames still pass a stalled tick result.
module bcd_display_mode_controller (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic [bcd_dmc_pkg::STATION_W-1:0]     i_cfg_wr_data,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // dest_addr[7:0], show_number[8], blink_number[9], show_point[10],
    // blink_point[11], timed[12], value[44:13], duration[76:45], zero[79:77]
    input  logic [bcd_dmc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // func[0]
    input  logic                                  s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // digit_enable[2:0], bcd_code[6:3], point[7]
    output logic [bcd_dmc_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import bcd_dmc_pkg::*;

    logic                    r_in_valid;
    logic [IN_DATA_W-1:0]    r_in_data;
    logic                    r_in_func;
    logic                    r_out_valid;
    logic [STATION_W-1:0]    r_station;

    logic [WORD_W-1:0]       r_tick,      n_tick;
    logic [M1000_W-1:0]      r_m1000,     n_m1000;
    logic [WORD_W-1:0]       r_shown,     n_shown;
    logic                    r_hold,      n_hold;
    logic [WORD_W-1:0]       r_time_left, n_time_left;
    logic [3:0]              r_flags,     n_flags;
    logic [ENABLE_W-1:0]     r_enable,    n_enable;
    logic [CODE_W-1:0]       r_code,      n_code;
    logic                    r_point,     n_point;

    logic                    test_mode;
    logic                    fire;
    logic                    fire_tick;
    logic [ADDR_W-1:0]       in_addr;
    logic [WORD_W-1:0]       tick_inc;
    logic [WORD_W-1:0]       test_tick;
    logic [WORD_W-1:0]       hold_tick;
    logic [M1000_W-1:0]      m_step;
    logic [M1000_W-1:0]      test_m;
    logic [M1000_W-1:0]      hold_m;
    logic [7:0]              scan_low;
    t_digit_sel              scan_sel;
    logic [ENABLE_W-1:0]     scan_enable;
    logic [CODE_W-1:0]       digit;
    logic [CODE_W-1:0]       unit_now;
    logic [CODE_W-1:0]       unit_next;
    logic                    test_step;
    logic                    expire;
    logic [M1000_W-1:0]      timed_m;

    assign test_mode = (r_station == '0) || r_station[TEST_BIT];
    assign fire      = r_in_valid && (r_in_func || !r_out_valid || m_axis_tready);
    assign fire_tick = fire && !r_in_func;
    assign s_axis_tready = !r_in_valid || fire;
    assign in_addr   = r_in_data[ADDR_W-1:0];

    assign tick_inc  = r_tick + 32'd1;
    assign test_tick = (tick_inc >= TEST_WRAP) ? '0 : tick_inc;
    assign hold_tick = (tick_inc >= BLINK_WRAP) ? '0 : tick_inc;
    assign m_step    = (tick_inc == '0) ? '0 :
                       ((r_m1000 == M1000_LAST) ? '0 : r_m1000 + 10'd1);
    assign test_m    = (test_tick == '0) ? '0 : m_step;
    assign hold_m    = (hold_tick == '0) ? '0 : m_step;

    assign scan_low  = test_mode ? test_tick[7:0] : (r_hold ? hold_tick[7:0] : tick_inc[7:0]);
    assign scan_sel  = f_scan_sel(scan_low);
    assign scan_enable = ENABLE_W'(1) << scan_sel;

    assign unit_now  = f_mod10_32(r_shown);
    assign unit_next = (unit_now == DIGIT_MAX) ? '0 : unit_now + 4'd1;
    assign test_step = (test_tick == '0) || (test_tick == TEST_STEP1) ||
                       (test_tick == TEST_STEP2);

    assign expire    = r_tick >= r_time_left;
    assign timed_m   = expire ? '0 : r_m1000;

    bcd_dmc_digit u_digit (
        .i_value (r_shown[SHOWN_W-1:0]),
        .i_sel   (scan_sel),
        .o_digit (digit)
    );

    always_comb begin
        n_tick      = r_tick;
        n_m1000     = r_m1000;
        n_shown     = r_shown;
        n_hold      = r_hold;
        n_time_left = r_time_left;
        n_flags     = r_flags;
        n_enable    = r_enable;
        n_code      = r_code;
        n_point     = r_point;
        if (fire) begin
            if (r_in_func) begin
                if (!test_mode && in_addr == {2'b00, r_station}) begin
                    n_tick  = '0;
                    n_m1000 = '0;
                    n_flags = r_in_data[11:8];
                    n_shown = r_in_data[44:13];
                    if (!r_in_data[12]) begin
                        n_hold = 1'b1;
                    end else begin
                        n_hold      = 1'b0;
                        n_time_left = r_in_data[76:45];
                    end
                end
            end else if (test_mode) begin
                n_tick   = test_tick;
                n_m1000  = test_m;
                n_enable = scan_enable;
                n_point  = 1'b0;
                if (test_step) begin
                    n_shown = 32'(unit_next) * TRIPLE_ONE;
                    n_code  = unit_next;
                end else begin
                    n_code  = digit;
                end
            end else if (r_hold) begin
                n_tick  = hold_tick;
                n_m1000 = hold_m;
                if (r_flags[0]) begin
                    if (r_flags[1] && !(hold_m > BLINK_HALF)) begin
                        n_enable = 3'b001;
                        n_code   = CODE_BLANK;
                        n_point  = 1'b1;
                    end else begin
                        n_enable = scan_enable;
                        n_code   = digit;
                        n_point  = 1'b0;
                    end
                end else if (r_flags[2]) begin
                    if (r_flags[3] && hold_m < BLINK_HALF) begin
                        n_enable = '0;
                        n_code   = CODE_BLANK;
                        n_point  = 1'b0;
                    end else begin
                        n_enable = 3'b001;
                        n_code   = CODE_BLANK;
                        n_point  = 1'b1;
                    end
                end
            end else if (r_time_left != '0) begin
                if (r_flags[0] && !expire) begin
                    n_tick  = tick_inc;
                    n_m1000 = m_step;
                    if (r_flags[1] && !(m_step > BLINK_HALF)) begin
                        n_enable = 3'b001;
                        n_code   = CODE_BLANK;
                        n_point  = 1'b1;
                    end else begin
                        n_enable = scan_enable;
                        n_code   = digit;
                        n_point  = 1'b0;
                    end
                end else begin
                    if (expire) begin
                        n_time_left = '0;
                        n_tick      = '0;
                        n_m1000     = '0;
                        n_enable    = '0;
                        n_code      = CODE_BLANK;
                        n_point     = 1'b0;
                    end
                    if (r_flags[2] && r_flags[3] &&
                        (timed_m == '0 || timed_m == BLINK_HALF)) begin
                        n_point = ~n_point;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_station   <= '0;
            r_tick      <= '0;
            r_m1000     <= '0;
            r_shown     <= '0;
            r_hold      <= 1'b0;
            r_time_left <= '0;
            r_flags     <= '0;
            r_enable    <= '0;
            r_code      <= CODE_BLANK;
            r_point     <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (fire_tick) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                r_station <= i_cfg_wr_data;
            end
            r_tick      <= n_tick;
            r_m1000     <= n_m1000;
            r_shown     <= n_shown;
            r_hold      <= n_hold;
            r_time_left <= n_time_left;
            r_flags     <= n_flags;
            r_enable    <= n_enable;
            r_code      <= n_code;
            r_point     <= n_point;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_data <= s_axis_tdata;
            r_in_func <= s_axis_tuser;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_point, r_code, r_enable};

endmodule

/* tb/sv/bcd_display_mode_controller_test.sv */
`timescale 1ns / 100ps
// Self-checking stream testbench for the BCD display mode controller.
module bcd_display_mode_controller_test;
    import bcd_dmc_pkg::*;

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_FRAME = 1'b1;

    localparam logic [3:0] F_NUM       = 4'b0001;
    localparam logic [3:0] F_NUM_BLINK = 4'b0010;
    localparam logic [3:0] F_PT        = 4'b0100;
    localparam logic [3:0] F_PT_BLINK  = 4'b1000;

    localparam logic [WORD_W-1:0] WORD_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic blink_point;
        logic show_point;
        logic blink_number;
        logic show_number;
    } t_flags;

    typedef struct packed {
        logic                 point;
        logic [CODE_W-1:0]    code;
        logic [ENABLE_W-1:0]  enable;
    } t_lines;

    typedef struct {
        logic               func;
        logic [ADDR_W-1:0]  dest_addr;
        t_flags             flags;
        logic               timed;
        logic [WORD_W-1:0]  value;
        logic [WORD_W-1:0]  duration;
    } t_item;

    typedef struct {
        bit                    is_cfg;
        logic [STATION_W-1:0]  id;
        t_item                 item;
        bit                    typed;
        t_lines                lines;
    } t_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_wr_en;
    logic [STATION_W-1:0]   i_cfg_wr_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;

    logic [WORD_W-1:0]     scan_count;
    logic [WORD_W-1:0]     disp_value;
    logic [WORD_W-1:0]     ticks_left;
    logic                  hold_on;
    t_flags                mode;
    t_lines                drive;
    logic [STATION_W-1:0]  station;

    t_lines expected_lines[$];
    t_row   directed_rows[$];

    int mismatches       = 0;
    int lines_checked    = 0;
    int counted_items    = 0;
    int ticks_sent       = 0;
    int frames_taken     = 0;
    int frames_ignored   = 0;
    int settings_written = 0;
    bit send_calm        = 1'b0;
    int send_calm_left   = 0;
    bit recv_calm        = 1'b0;
    int recv_calm_left   = 0;

    bcd_display_mode_controller DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit test_mode();
        return station == '0 || station[TEST_BIT];
    endfunction

    function automatic void drive_blank();
        drive.enable = '0;
        drive.code   = CODE_BLANK;
        drive.point  = 1'b0;
    endfunction

    function automatic void drive_point_on();
        drive.enable = 3'b001;
        drive.code   = CODE_BLANK;
        drive.point  = 1'b1;
    endfunction

    function automatic void drive_digit();
        t_digit_sel   sel;
        logic [15:0]  n;
        sel = t_digit_sel'(2'(scan_count[7:0] % 8'd3));
        n = disp_value[SHOWN_W-1:0];
        drive.point = 1'b0;
        case (sel)
            SEL_UNITS: begin
                drive.enable = 3'b001;
                drive.code   = 4'(n % 16'd10);
            end
            SEL_TENS: begin
                drive.enable = 3'b010;
                drive.code   = 4'((n % 16'd100) / 16'd10);
            end
            default: begin
                drive.enable = 3'b100;
                drive.code   = 4'((n % 16'd1000) / 16'd100);
            end
        endcase
    endfunction

    function automatic void number_lines();
        if (mode.blink_number) begin
            if (scan_count % BLINK_WRAP > 32'(BLINK_HALF)) begin
                drive_digit();
            end else begin
                drive_point_on();
            end
        end else begin
            drive_digit();
        end
    endfunction

    // Returns whether the item had any effect; a tick always yields display lines.
    function automatic bit predict_display_lines(input t_item it, output bit has_line,
                                                 output t_lines ln);
        logic [3:0] d;
        has_line = 1'b0;
        ln = drive;
        if (it.func == FUNC_FRAME) begin
            if (test_mode() || it.dest_addr != {2'b00, station}) begin
                return 1'b0;
            end
            scan_count = '0;
            mode = it.flags;
            disp_value = it.value;
            if (!it.timed) begin
                hold_on = 1'b1;
            end else begin
                hold_on = 1'b0;
                ticks_left = it.duration;
            end
            return 1'b1;
        end
        has_line = 1'b1;
        if (test_mode()) begin
            scan_count = scan_count + 1;
            if (scan_count >= TEST_WRAP) begin
                scan_count = '0;
            end
            if (scan_count % TEST_STEP1 == 0) begin
                d = 4'(disp_value % 32'd10);
                disp_value = (d == DIGIT_MAX) ? '0 : (32'(d) + 32'd1) * TRIPLE_ONE;
            end
            drive_digit();
        end else if (hold_on) begin
            scan_count = scan_count + 1;
            if (scan_count >= BLINK_WRAP) begin
                scan_count = '0;
            end
            if (mode.show_number) begin
                number_lines();
            end else if (mode.show_point) begin
                if (mode.blink_point && scan_count % BLINK_WRAP < 32'(BLINK_HALF)) begin
                    drive_blank();
                end else begin
                    drive_point_on();
                end
            end
        end else if (ticks_left != '0) begin
            if (scan_count >= ticks_left) begin
                ticks_left = '0;
                scan_count = '0;
                drive_blank();
            end
            if (mode.show_number && ticks_left != '0) begin
                scan_count = scan_count + 1;
                number_lines();
            end else if (mode.show_point && mode.blink_point &&
                         scan_count % 32'(BLINK_HALF) == 0) begin
                drive.point = ~drive.point;
            end
        end
        ln = drive;
        return 1'b1;
    endfunction

    function automatic t_item random_item();
        t_item it;
        it.func      = 1'($urandom_range(0, 1));
        it.dest_addr = 8'($urandom_range(0, 255));
        it.flags     = t_flags'(4'($urandom_range(0, 15)));
        it.timed     = 1'($urandom_range(0, 1));
        it.value     = $urandom();
        it.duration  = $urandom();
        return it;
    endfunction

    function automatic t_row tick_row(input bit typed, input logic [2:0] en,
                                      input logic [3:0] code, input logic pt);
        t_row r;
        r = '{default: '0};
        r.item = random_item();
        r.item.func = FUNC_TICK;
        r.typed = typed;
        r.lines = {pt, code, en};
        return r;
    endfunction

    function automatic t_row frame_row(input logic [7:0] addr, input logic [3:0] flags,
                                       input logic timed, input logic [31:0] value,
                                       input logic [31:0] duration);
        t_row r;
        r = '{default: '0};
        r.item.func      = FUNC_FRAME;
        r.item.dest_addr = addr;
        r.item.flags     = t_flags'(flags);
        r.item.timed     = timed;
        r.item.value     = value;
        r.item.duration  = duration;
        return r;
    endfunction

    function automatic t_row cfg_row(input logic [5:0] id);
        t_row r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.id = id;
        return r;
    endfunction

    task automatic offer_item(input t_item it, input bit typed, input t_lines typed_lines);
        int      gap;
        bit      has_line;
        bit      taken;
        t_lines  ln;
        if (send_calm_left == 0) begin
            send_calm = ($urandom_range(0, 3) == 0);
            send_calm_left = $urandom_range(20, 80);
        end
        send_calm_left--;
        gap = send_calm ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.func;
        s_axis_tdata  <= {3'b000, it.duration, it.value, it.timed, it.flags, it.dest_addr};
        do @(posedge i_clk); while (!s_axis_tready);
        taken = predict_display_lines(it, has_line, ln);
        if (has_line) begin
            expected_lines.push_back(typed ? typed_lines : ln);
        end
        if (it.func == FUNC_TICK) begin
            ticks_sent++;
        end else if (taken) begin
            frames_taken++;
        end else begin
            frames_ignored++;
        end
        if (taken) begin
            counted_items++;
        end
    endtask

    task automatic write_station_id(input logic [STATION_W-1:0] id);
        s_axis_tvalid <= 1'b0;
        wait (expected_lines.size() == 0);
        repeat (4) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= id;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        station = id;
        settings_written++;
    endtask

    // Mostly frames addressed to this station followed by a run of ticks,
    // some of them long enough to reach the blink half period.
    task automatic random_phase(input int target);
        int     stop_at;
        int     run;
        t_item  it;
        stop_at = counted_items + target;
        while (counted_items < stop_at) begin
            it = random_item();
            it.func = FUNC_FRAME;
            if ($urandom_range(0, 99) < 85) begin
                it.dest_addr = {2'b00, station};
            end
            case ($urandom_range(0, 9))
                0: begin
                end
                1, 2: it.duration = $urandom_range(0, 20);
                default: it.duration = $urandom_range(0, 1500);
            endcase
            if ($urandom_range(0, 1)) begin
                it.value = $urandom_range(0, 999);
            end
            offer_item(it, 1'b0, '0);
            run = ($urandom_range(0, 4) == 0) ? $urandom_range(400, 700) : $urandom_range(1, 30);
            for (int k = 0; k < run && counted_items < stop_at; k++) begin
                it = random_item();
                it.func = FUNC_TICK;
                offer_item(it, 1'b0, '0);
            end
        end
    endtask

    initial begin
        logic [STATION_W-1:0] phase_id [7];
        int                   phase_len [7];
        phase_id  = '{6'd0, 6'd63, 6'd1, 6'd31, 6'd32, 6'd0, 6'd0};
        phase_len = '{550, 300, 250, 250, 100, 150, 150};
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= FUNC_TICK;
        scan_count = '0;
        disp_value = '0;
        ticks_left = '0;
        hold_on    = 1'b0;
        mode       = '0;
        drive      = {1'b0, CODE_BLANK, 3'b000};
        station    = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed_rows.push_back(tick_row(1, 3'b010, 4'd0, 1'b0));
        directed_rows.push_back(frame_row(8'd0, 4'hF, 1'b1, WORD_MAX, WORD_MAX));
        directed_rows.push_back(tick_row(1, 3'b100, 4'd0, 1'b0));
        directed_rows.push_back(cfg_row(6'd63));
        directed_rows.push_back(tick_row(1, 3'b001, 4'd0, 1'b0));
        directed_rows.push_back(cfg_row(6'd1));
        directed_rows.push_back(frame_row(8'd1, F_NUM, 1'b0, WORD_MAX, '0));
        directed_rows.push_back(tick_row(0, '0, '0, 1'b0));
        directed_rows.push_back(frame_row(8'd65, '0, 1'b0, '0, '0));
        directed_rows.push_back(frame_row(8'd255, '0, 1'b1, '0, '0));
        directed_rows.push_back(tick_row(0, '0, '0, 1'b0));
        directed_rows.push_back(frame_row(8'd1, F_PT, 1'b0, '0, '0));
        directed_rows.push_back(tick_row(1, 3'b001, CODE_BLANK, 1'b1));
        directed_rows.push_back(frame_row(8'd1, F_PT | F_PT_BLINK, 1'b0, '0, '0));
        directed_rows.push_back(tick_row(1, 3'b000, CODE_BLANK, 1'b0));
        directed_rows.push_back(frame_row(8'd1, '0, 1'b0, 32'd7, '0));
        directed_rows.push_back(tick_row(1, 3'b000, CODE_BLANK, 1'b0));
        directed_rows.push_back(frame_row(8'd1, F_NUM | F_NUM_BLINK, 1'b0, 32'd42, '0));
        directed_rows.push_back(tick_row(1, 3'b001, CODE_BLANK, 1'b1));
        directed_rows.push_back(frame_row(8'd1, F_NUM, 1'b1, 32'd5, '0));
        directed_rows.push_back(tick_row(1, 3'b001, CODE_BLANK, 1'b1));
        directed_rows.push_back(frame_row(8'd1, F_NUM, 1'b1, 32'd123, 32'd2));
        directed_rows.push_back(tick_row(0, '0, '0, 1'b0));
        directed_rows.push_back(tick_row(0, '0, '0, 1'b0));
        directed_rows.push_back(tick_row(1, 3'b000, CODE_BLANK, 1'b0));
        directed_rows.push_back(frame_row(8'd1, F_PT | F_PT_BLINK, 1'b1, '0, 32'd3));
        directed_rows.push_back(tick_row(1, 3'b000, CODE_BLANK, 1'b1));
        directed_rows.push_back(tick_row(1, 3'b000, CODE_BLANK, 1'b0));
        directed_rows.push_back(frame_row(8'd1, '0, 1'b1, '0, WORD_MAX));
        directed_rows.push_back(tick_row(1, 3'b000, CODE_BLANK, 1'b0));
        directed_rows.push_back(frame_row(8'd1, F_NUM | F_PT | F_PT_BLINK, 1'b1, '0, 32'd1));
        directed_rows.push_back(tick_row(0, '0, '0, 1'b0));
        directed_rows.push_back(tick_row(1, 3'b000, CODE_BLANK, 1'b1));

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg) begin
                write_station_id(directed_rows[i].id);
            end else begin
                offer_item(directed_rows[i].item, directed_rows[i].typed,
                           directed_rows[i].lines);
            end
        end

        for (int p = 0; p < 7; p++) begin
            write_station_id((p >= 5) ? 6'($urandom_range(2, 30)) : phase_id[p]);
            random_phase(phase_len[p]);
        end

        s_axis_tvalid <= 1'b0;
        wait (expected_lines.size() == 0);
        repeat (8) @(posedge i_clk);
        $display("Sent %0d ticks and %0d frames (%0d ignored) over %0d station id settings;",
                 ticks_sent, frames_taken + frames_ignored, frames_ignored, settings_written);
        $display("checked %0d display transactions, %0d mismatches.", lines_checked, mismatches);
        if (mismatches == 0) begin
            $display("bcd_display_mode_controller regression: pass");
        end else begin
            $display("bcd_display_mode_controller regression: fail");
        end
        $finish;
    end

    initial begin
        int      stall;
        t_lines  got;
        t_lines  want;
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (recv_calm_left == 0) begin
                recv_calm = ($urandom_range(0, 3) == 0);
                recv_calm_left = $urandom_range(20, 80);
            end
            recv_calm_left--;
            stall = recv_calm ? 0 : $urandom_range(0, 11);
            // A long hold-off lets the block fill up and back-pressure the input.
            if (lines_checked % 700 == 300) begin
                stall = 400;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            got = t_lines'(m_axis_tdata);
            if (expected_lines.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected display transaction, actual %h", $time, got);
            end else begin
                want = expected_lines.pop_front();
                if (got.enable !== want.enable) begin
                    mismatches++;
                    $display("%0t: digit_enable expected %b actual %b",
                             $time, want.enable, got.enable);
                end
                if (got.code !== want.code) begin
                    mismatches++;
                    $display("%0t: bcd_code expected %0d actual %0d", $time, want.code, got.code);
                end
                if (got.point !== want.point) begin
                    mismatches++;
                    $display("%0t: point expected %b actual %b", $time, want.point, got.point);
                end
            end
            lines_checked++;
        end
    end

    initial begin
        #5_000_000;
        $display("bcd_display_mode_controller regression: fail");
        $finish;
    end

endmodule
